[design/rcu_pkg.sv]
`default_nettype none

package rcu_pkg;

  localparam int unsigned FIELD_BITS   = 11;
  localparam int unsigned ACC_BITS     = 18;
  localparam int unsigned HELD_BITS    = 5;
  localparam int unsigned DONE_BITS    = 5;
  localparam int unsigned INDEX_BITS   = 4;
  localparam int unsigned PULSE_BITS   = 12;

  localparam int unsigned SCALE_SHIFT  = 10;
  localparam int unsigned SCALE_DIV    = 1639;
  localparam int unsigned SCALE_RECIP  = 2620480;
  localparam int unsigned RECIP_BITS   = 22;
  localparam int unsigned RECIP_SHIFT  = 22;
  localparam int unsigned PULSE_OFFSET = 881;

  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QUEUE_PTR_W  = 1;
  localparam int unsigned QUEUE_CNT_W  = 2;

  typedef struct packed {
    logic [INDEX_BITS-1:0] index;
    logic [FIELD_BITS-1:0] value;
    logic                  last;
  } entry_t;

endpackage

`default_nettype wire

[design/rcu_if.sv]
`default_nettype none

interface rcu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface rcu_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  channel_index;
  logic [11:0] pulse_us;
  logic        last_channel;

  modport source (output valid, output channel_index, output pulse_us, output last_channel,
                  input ready);
  modport sink   (input valid, input channel_index, input pulse_us, input last_channel,
                  output ready);
endinterface

`default_nettype wire

[design/rc_channel_unpack_to_pulse.sv]
// Packed 11-bit RC channel decoder with pulse-width scaling.
// Throughput: one byte per cycle while the queue is not full; a byte that completes a channel sits in a
// two-entry queue, then passes a two-stage scaling pipeline (reciprocal multiply, correction).
// The completing byte is written into the queue, then registered in stage 1 and in the output register;
// an output stall holds it behind any earlier transaction still waiting ahead of it.
// Reset: asynchronous, active low; decoder idles until a byte with frame_start.
`default_nettype none

module rc_channel_unpack_to_pulse #(
  parameter int unsigned CHANNEL_COUNT = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rcu_in_if.sink    in_i,
  rcu_out_if.source out_o
);

  logic            q_full, q_valid, q_pop, push, accept;
  rcu_pkg::entry_t push_entry, q_entry;

  assign in_i.ready = !q_full;
  assign accept     = in_i.valid && !q_full;

  rcu_front #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (in_i.data_byte),
    .frame_start_i (in_i.frame_start),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  rcu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  rcu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .entry_i (q_entry),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

[design/rcu_front.sv]
`default_nettype none

module rcu_front #(
  parameter int unsigned CHANNEL_COUNT = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                frame_start_i,
  output      logic                push_o,
  output      rcu_pkg::entry_t     entry_o
);

  localparam logic [rcu_pkg::DONE_BITS-1:0] ChanLimit =
      rcu_pkg::DONE_BITS'(CHANNEL_COUNT);

  logic [rcu_pkg::ACC_BITS-1:0]  acc_q, acc_d, acc_base, acc_new;
  logic [rcu_pkg::HELD_BITS-1:0] held_q, held_d, held_base, held_new;
  logic [rcu_pkg::DONE_BITS-1:0] done_q, done_d, done_base;
  logic                          active;
  logic                          emit;

  always_comb begin
    acc_base  = frame_start_i ? '0 : acc_q;
    held_base = frame_start_i ? '0 : held_q;
    done_base = frame_start_i ? '0 : done_q;
    active    = done_base < ChanLimit;
    acc_new   = acc_base |
                (rcu_pkg::ACC_BITS'(data_byte_i) << held_base);
    held_new  = held_base + rcu_pkg::HELD_BITS'(8);
    emit      = accept_i && active &&
                (held_new >= rcu_pkg::HELD_BITS'(rcu_pkg::FIELD_BITS));

    acc_d  = acc_q;
    held_d = held_q;
    done_d = done_q;
    if (accept_i) begin
      acc_d  = acc_base;
      held_d = held_base;
      done_d = done_base;
      if (active) begin
        acc_d  = acc_new;
        held_d = held_new;
        if (emit) begin
          acc_d  = acc_new >> rcu_pkg::FIELD_BITS;
          held_d = held_new - rcu_pkg::HELD_BITS'(rcu_pkg::FIELD_BITS);
          done_d = done_base + rcu_pkg::DONE_BITS'(1);
        end
      end
    end

    push_o        = emit;
    entry_o.index = done_base[rcu_pkg::INDEX_BITS-1:0];
    entry_o.value = acc_new[rcu_pkg::FIELD_BITS-1:0];
    entry_o.last  = (done_base == ChanLimit - rcu_pkg::DONE_BITS'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      held_q <= '0;
      done_q <= rcu_pkg::DONE_BITS'(16);
    end else begin
      acc_q  <= acc_d;
      held_q <= held_d;
      done_q <= done_d;
    end
  end

endmodule

`default_nettype wire

[design/rcu_queue.sv]
`default_nettype none

module rcu_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire rcu_pkg::entry_t entry_i,
  input  wire logic            pop_i,
  output      logic            full_o,
  output      logic            valid_o,
  output      rcu_pkg::entry_t entry_o
);

  rcu_pkg::entry_t mem_q [rcu_pkg::QUEUE_DEPTH];

  logic [rcu_pkg::QUEUE_PTR_W-1:0] wr_q, rd_q;
  logic [rcu_pkg::QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic                            do_push, do_pop;

  always_comb begin
    full_o  = (cnt_q == rcu_pkg::QUEUE_CNT_W'(rcu_pkg::QUEUE_DEPTH));
    valid_o = (cnt_q != '0);
    entry_o = mem_q[rd_q];
    do_push = push_i && !full_o;
    do_pop  = pop_i && valid_o;
    cnt_d   = cnt_q + rcu_pkg::QUEUE_CNT_W'(do_push) - rcu_pkg::QUEUE_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= wr_q + rcu_pkg::QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + rcu_pkg::QUEUE_PTR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[design/rcu_back.sv]
`default_nettype none

module rcu_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire rcu_pkg::entry_t entry_i,
  output      logic            pop_o,
  rcu_out_if.source            out_o
);

  localparam int unsigned ProdW = rcu_pkg::FIELD_BITS + rcu_pkg::RECIP_BITS;
  localparam int unsigned NumW  = rcu_pkg::FIELD_BITS + rcu_pkg::SCALE_SHIFT;

  // stage 1: quotient estimate, may be one low
  logic                                 s1_valid_q;
  rcu_pkg::entry_t                      s1_entry_q;
  logic [rcu_pkg::FIELD_BITS-1:0]       s1_quot_q;
  logic [ProdW-1:0]                     prod;

  // stage 2: correction and offset
  logic                                 out_valid_q;
  logic [rcu_pkg::INDEX_BITS-1:0]       out_index_q;
  logic [rcu_pkg::PULSE_BITS-1:0]       out_pulse_q;
  logic                                 out_last_q;

  logic                                 out_free, s1_take;
  logic [NumW-1:0]                      num, back_prod, rem;
  logic [rcu_pkg::FIELD_BITS-1:0]       quot;
  logic [rcu_pkg::PULSE_BITS-1:0]       pulse;

  always_comb begin
    out_free  = !out_valid_q || out_o.ready;
    s1_take   = !s1_valid_q || out_free;
    pop_o     = valid_i && s1_take;
    prod      = ProdW'(entry_i.value) * ProdW'(rcu_pkg::SCALE_RECIP);

    num       = NumW'(s1_entry_q.value) << rcu_pkg::SCALE_SHIFT;
    back_prod = NumW'(s1_quot_q) * NumW'(rcu_pkg::SCALE_DIV);
    rem       = num - back_prod;
    quot      = s1_quot_q + rcu_pkg::FIELD_BITS'(rem >= NumW'(rcu_pkg::SCALE_DIV));
    pulse     = rcu_pkg::PULSE_BITS'(quot) + rcu_pkg::PULSE_BITS'(rcu_pkg::PULSE_OFFSET);

    out_o.valid         = out_valid_q;
    out_o.channel_index = out_index_q;
    out_o.pulse_us      = out_pulse_q;
    out_o.last_channel  = out_last_q;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_entry_q <= entry_i;
      s1_quot_q  <= prod[rcu_pkg::RECIP_SHIFT +: rcu_pkg::FIELD_BITS];
    end
    if (s1_valid_q && out_free) begin
      out_index_q <= s1_entry_q.index;
      out_pulse_q <= pulse;
      out_last_q  <= s1_entry_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid_q <= valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CHANNELS    = 16;
  localparam int unsigned FRAME_BYTES = 22;
  localparam int unsigned FIELD_W     = 11;
  localparam int unsigned PULSE_MUL   = 1024;
  localparam int unsigned PULSE_DIV   = 1639;
  localparam int unsigned PULSE_BASE  = 881;
  localparam int unsigned MAX_GAP     = 15;
  localparam int unsigned SETTLE      = 12;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          MAX_PRINTS  = 40;

  typedef struct {
    logic [3:0]  index;
    logic [11:0] pulse;
    logic        last;
  } channel_t;

  typedef enum int {BYTE_IGNORED, BYTE_TAKEN, CHANNEL_OUT} byte_fate_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  rcu_in_if  in_if ();
  rcu_out_if out_if ();

  rc_channel_unpack_to_pulse #(
    .CHANNEL_COUNT(CHANNELS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // decoder shadow state
  logic [17:0] acc_bits;
  logic [4:0]  acc_count;
  logic [4:0]  chans_out;

  channel_t expected_channels[$];
  int       errors = 0;
  int       cycles = 0;
  bit       idle_on = 1'b1;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic report(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("tb: mismatch at cycle %0d: %s", cycles, msg);
  endtask

  function automatic byte_fate_e decode_byte(input logic [7:0] b, input logic s,
                                             output channel_t c);
    logic [10:0] v;
    c = '{default: '0};
    if (s) begin
      acc_bits  = '0;
      acc_count = '0;
      chans_out = '0;
    end
    if (chans_out >= CHANNELS) return BYTE_IGNORED;
    acc_bits  = acc_bits | (18'(b) << acc_count);
    acc_count = acc_count + 5'd8;
    if (acc_count < FIELD_W) return BYTE_TAKEN;
    v         = acc_bits[10:0];
    acc_bits  = acc_bits >> FIELD_W;
    acc_count = acc_count - 5'(FIELD_W);
    c.index   = chans_out[3:0];
    c.pulse   = 12'((int'(v) * PULSE_MUL) / PULSE_DIV + PULSE_BASE);
    c.last    = (chans_out == CHANNELS - 1);
    chans_out = chans_out + 5'd1;
    return CHANNEL_OUT;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one transaction on the byte channel; prediction at acceptance
  task automatic send_byte(input logic [7:0] b, input logic s, output byte_fate_e fate);
    int       gap;
    channel_t c;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b;
    in_if.frame_start <= s;
    do @(posedge clk_i); while (!in_if.ready);
    fate = decode_byte(b, s, c);
    if (fate == CHANNEL_OUT) expected_channels.push_back(c);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_channels.size() != 0);
  endtask

  // receiver: random stall before each transaction
  initial begin
    int stall;
    out_if.ready = 1'b0;
    forever begin
      stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  always @(posedge clk_i) begin
    channel_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_channels.size() == 0) begin
        report($sformatf("unexpected channel %0d pulse %0d",
                         out_if.channel_index, out_if.pulse_us));
      end else begin
        want = expected_channels.pop_front();
        if (out_if.channel_index !== want.index)
          report($sformatf("channel_index %0d, want %0d", out_if.channel_index, want.index));
        if (out_if.pulse_us !== want.pulse)
          report($sformatf("ch %0d pulse_us %0d, want %0d",
                           want.index, out_if.pulse_us, want.pulse));
        if (out_if.last_channel !== want.last)
          report($sformatf("ch %0d last_channel %0b, want %0b",
                           want.index, out_if.last_channel, want.last));
      end
    end
  end

  // bytes before any frame start must be dropped
  task automatic test_idle_bytes();
    byte_fate_e fate;
    send_byte(8'hFF, 1'b0, fate);
  endtask

  // partial frame holding a full-scale channel, cut off by a new start
  task automatic test_partial_frame();
    byte_fate_e fate;
    send_byte(8'hFF, 1'b1, fate);
    send_byte(8'hFF, 1'b0, fate);
  endtask

  // complete frame: ch0 zero, ch1 full scale, last mark, then a trailing byte
  task automatic test_full_frame();
    byte_fate_e fate;
    logic [7:0] b;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      case (i)
        0: b = 8'h00;
        1: b = 8'hF8;
        2: b = 8'h3F;
        default: b = rand_byte();
      endcase
      send_byte(b, i == 0, fate);
    end
    send_byte(8'h5A, 1'b0, fate);
  endtask

  task automatic test_random_frames(input int target);
    byte_fate_e fate;
    int         taken;
    int         kind;
    int         len;
    taken = 0;
    while (taken < target) begin
      idle_on = ($urandom_range(0, 3) != 0);
      kind    = $urandom_range(0, 9);
      if (kind < 7) len = FRAME_BYTES + $urandom_range(0, 2);
      else if (kind < 9) len = $urandom_range(1, FRAME_BYTES - 1);
      else len = 0;
      if (len > 0) begin
        for (int i = 0; i < len; i++) begin
          send_byte(rand_byte(), i == 0, fate);
          if (fate != BYTE_IGNORED) taken++;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_byte(rand_byte(), $urandom_range(0, 3) == 0, fate);
          if (fate != BYTE_IGNORED) taken++;
        end
      end
    end
    idle_on = 1'b1;
  endtask

  // sender holds off until the pipeline is empty
  task automatic test_drain();
    wait_drained();
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.data_byte   = '0;
    in_if.frame_start = 1'b0;
    acc_bits          = '0;
    acc_count         = '0;
    chans_out         = 5'(CHANNELS);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_bytes();
    test_partial_frame();
    test_full_frame();
    test_random_frames(600);
    test_drain();
    test_random_frames(650);

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
